### sv/usb_control_endpoint_responder_macros.svh
// Assertion helpers for the endpoint-zero responder
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_MACROS_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_MACROS_SVH

// Implication checked on every rising edge outside reset
`define USBCER_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("usbcer assertion failed");

// Next-cycle implication
`define USBCER_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("usbcer assertion failed");

`endif

### sv/usbcer_pkg.sv
package usbcer_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] sel;
        logic [7:0] pos;
    } rom_req_t;

    localparam logic [2:0] SEL_DEV    = 3'd0;
    localparam logic [2:0] SEL_CFG    = 3'd1;
    localparam logic [2:0] SEL_LANG   = 3'd2;
    localparam logic [2:0] SEL_MFG    = 3'd3;
    localparam logic [2:0] SEL_PROD   = 3'd4;
    localparam logic [2:0] SEL_CODING = 3'd5;

    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_CLASS    = 2'd1;

    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    localparam logic [7:0] DEV_LEN    = 8'd18;
    localparam logic [7:0] CFG_LEN    = 8'd141;
    localparam logic [7:0] LANG_LEN   = 8'd4;
    localparam logic [7:0] MFG_LEN    = 8'd16;
    localparam logic [7:0] PROD_LEN   = 8'd42;
    localparam logic [7:0] CODING_LEN = 8'd7;

    localparam logic [7:0] DEV_ROM [18] = '{
        8'd18, 8'd1, 8'h00, 8'h02, 8'hEF, 8'h02, 8'h01, 8'd64, 8'h8A, 8'h2E, 8'h0A, 8'h00,
        8'h00, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1};

    localparam logic [7:0] CFG_ROM [141] = '{
        8'd9, 8'd2, 8'd141, 8'd0, 8'd4, 8'd1, 8'd0, 8'hC0, 8'd50,
        8'd8, 8'd11, 8'd0, 8'd2, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd5, 8'd36, 8'd0, 8'h10, 8'h01,
        8'd4, 8'd36, 8'd2, 8'd2,
        8'd5, 8'd36, 8'd6, 8'd0, 8'd1,
        8'd5, 8'd36, 8'd1, 8'd0, 8'd1,
        8'd7, 8'd5, 8'h81, 8'd3, 8'd16, 8'd0, 8'd16,
        8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'd10, 8'd0, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h02, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h82, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd8, 8'd11, 8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd9, 8'd4, 8'd2, 8'd0, 8'd1, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd5, 8'd36, 8'd0, 8'h10, 8'h01,
        8'd4, 8'd36, 8'd2, 8'd2,
        8'd5, 8'd36, 8'd6, 8'd2, 8'd3,
        8'd5, 8'd36, 8'd1, 8'd0, 8'd3,
        8'd7, 8'd5, 8'h83, 8'd3, 8'd16, 8'd0, 8'd16,
        8'd9, 8'd4, 8'd3, 8'd0, 8'd2, 8'd10, 8'd0, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h04, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h84, 8'd2, 8'd64, 8'd0, 8'd0};

    localparam logic [7:0] LANG_ROM [4] = '{8'd4, 8'd3, 8'h09, 8'h04};

    localparam logic [7:0] MFG_ROM [16] = '{
        8'd16, 8'd3, 8'h4C, 8'h0, 8'h75, 8'h0, 8'h67, 8'h0,
        8'h61, 8'h0, 8'h6C, 8'h0, 8'h4F, 8'h0, 8'h53, 8'h0};

    localparam logic [7:0] PROD_ROM [42] = '{
        8'd42, 8'd3, 8'h4C, 8'h0, 8'h75, 8'h0, 8'h67, 8'h0, 8'h61, 8'h0, 8'h6C, 8'h0,
        8'h4F, 8'h0, 8'h53, 8'h0, 8'h20, 8'h0, 8'h44, 8'h0, 8'h75, 8'h0, 8'h61, 8'h0,
        8'h6C, 8'h0, 8'h20, 8'h0, 8'h43, 8'h0, 8'h44, 8'h0, 8'h43, 8'h0, 8'h20, 8'h0,
        8'h41, 8'h0, 8'h43, 8'h0, 8'h4D, 8'h0};

    localparam logic [7:0] CODING_ROM [7] = '{8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08};

    function automatic logic [7:0] rom_byte(input logic [2:0] sel, input logic [7:0] pos);
        logic [7:0] b;
        b = 8'h00;
        case (sel)
            SEL_DEV:    if (pos < DEV_LEN)    b = DEV_ROM[pos[4:0]];
            SEL_CFG:    if (pos < CFG_LEN)    b = CFG_ROM[pos];
            SEL_LANG:   if (pos < LANG_LEN)   b = LANG_ROM[pos[1:0]];
            SEL_MFG:    if (pos < MFG_LEN)    b = MFG_ROM[pos[3:0]];
            SEL_PROD:   if (pos < PROD_LEN)   b = PROD_ROM[pos[5:0]];
            SEL_CODING: if (pos < CODING_LEN) b = CODING_ROM[pos[2:0]];
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### sv/usbcer_rom.sv
module usbcer_rom (
    input  logic                clk,
    input  usbcer_pkg::rom_req_t req,
    output logic [7:0]          data
);
    import usbcer_pkg::*;

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= rom_byte(req.sel, req.pos);
    end

    assign data = data_reg;
endmodule

### sv/usb_control_endpoint_responder.sv
// Endpoint-zero control responder.
// in_*  : one poll event per transfer; tdata = bus_reset_seen, ack_received,
//         transfer_complete, setup_received, request_type, request_code,
//         request_value, request_length (lowest bit first).
// out_* : result items; tlast marks the last result of an event.
// cfg_* : write of the enable bit; always ready. Events arriving while
//         disabled are taken and dropped.
// An event is decoded in the cycle it is taken. Events with no action give
// no result and the block is ready again next cycle. Otherwise each data
// byte is read from the descriptor ROM (FETCH) and then output (EMIT);
// a control-only result goes straight to EMIT.
// in_tready is high only while idle, so a stalled receiver holds the
// current result and blocks further events; nothing is lost.
// Reset clears the endpoint state (not the held result fields): address not pending,
// nothing left to send, next PID DATA1, block disabled.
`include "usb_control_endpoint_responder_macros.svh"
module usb_control_endpoint_responder #(
    parameter int PACKET_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_tvalid,
    output logic        in_tready,
    input  logic [55:0] in_tdata,   // flags[3:0], type, code, value, length
    output logic        out_tvalid,
    input  logic        out_tready,
    output logic [39:0] out_tdata,  // data_byte, byte_index, data_valid,
                                    // in_control_valid, in_length,
                                    // in_last_buffer, in_data1, out_arm,
                                    // address_write, address_value
    output logic        out_tlast
);
    import usbcer_pkg::*;

    localparam logic [7:0] PKT = 8'(PACKET_BYTES);

    state_t     state_reg, state_next;
    logic       enabled_reg;
    logic [2:0] sel_reg, sel_next;
    logic [7:0] offset_reg, offset_next;
    logic [7:0] remain_reg, remain_next;
    logic       pid_reg, pid_next;
    logic [6:0] paddr_reg, paddr_next;
    logic       apend_reg, apend_next;
    logic       rsth_reg, rsth_next;
    logic [7:0] base_reg, base_next;
    logic [6:0] nbytes_reg, nbytes_next;
    logic [5:0] idx_reg, idx_next;
    logic       ctrl_reg, ctrl_next;
    logic [6:0] len_reg, len_next;
    logic       lbuf_reg, lbuf_next;
    logic       d1_reg, d1_next;
    logic       arm_reg, arm_next;
    logic       aw_reg, aw_next;
    logic [6:0] av_reg, av_next;

    rom_req_t   rom_req;
    logic [7:0] rom_data;

    logic       ev_reset, ev_ack, ev_done, ev_setup;
    logic [7:0] ev_type, ev_code;
    logic [15:0] ev_value, ev_length;
    logic       fin;

    assign ev_reset  = in_tdata[0];
    assign ev_ack    = in_tdata[1];
    assign ev_done   = in_tdata[2];
    assign ev_setup  = in_tdata[3];
    assign ev_type   = in_tdata[11:4];
    assign ev_code   = in_tdata[19:12];
    assign ev_value  = in_tdata[35:20];
    assign ev_length = in_tdata[51:36];

    assign cfg_ready = 1'b1;

    assign rom_req.sel = sel_reg;
    assign rom_req.pos = base_reg + {2'b00, idx_reg};

    usbcer_rom u_rom (
        .clk  (clk),
        .req  (rom_req),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            enabled_reg <= 1'b0;
            sel_reg     <= 3'd0;
            offset_reg  <= 8'd0;
            remain_reg  <= 8'd0;
            pid_reg     <= 1'b1;
            paddr_reg   <= 7'd0;
            apend_reg   <= 1'b0;
            rsth_reg    <= 1'b0;
            idx_reg     <= 6'd0;
            nbytes_reg  <= 7'd0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                enabled_reg <= cfg_data;
            end
            sel_reg    <= sel_next;
            offset_reg <= offset_next;
            remain_reg <= remain_next;
            pid_reg    <= pid_next;
            paddr_reg  <= paddr_next;
            apend_reg  <= apend_next;
            rsth_reg   <= rsth_next;
            idx_reg    <= idx_next;
            nbytes_reg <= nbytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        ctrl_reg <= ctrl_next;
        len_reg  <= len_next;
        lbuf_reg <= lbuf_next;
        d1_reg   <= d1_next;
        arm_reg  <= arm_next;
        aw_reg   <= aw_next;
        av_reg   <= av_next;
    end

    always_comb
    begin
        logic [7:0] rem1;
        logic [7:0] chunk;
        logic [7:0] slen;
        logic       cont;
        logic       start;
        logic       ackr;
        logic [2:0] ssel;
        logic [1:0] kind;

        state_next  = state_reg;
        sel_next    = sel_reg;
        offset_next = offset_reg;
        remain_next = remain_reg;
        pid_next    = pid_reg;
        paddr_next  = paddr_reg;
        apend_next  = apend_reg;
        rsth_next   = rsth_reg;
        idx_next    = idx_reg;
        nbytes_next = nbytes_reg;
        base_next   = base_reg;
        ctrl_next   = ctrl_reg;
        len_next    = len_reg;
        lbuf_next   = lbuf_reg;
        d1_next     = d1_reg;
        arm_next    = arm_reg;
        aw_next     = aw_reg;
        av_next     = av_reg;
        rem1  = 8'd0;
        chunk = 8'd0;
        slen  = 8'd0;
        cont  = 1'b0;
        start = 1'b0;
        ackr  = 1'b0;
        ssel  = SEL_DEV;
        kind  = ev_type[6:5];
        in_tready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_tvalid && enabled_reg)
                begin
                    ctrl_next = 1'b0;
                    len_next  = 7'd0;
                    lbuf_next = 1'b0;
                    d1_next   = 1'b0;
                    arm_next  = 1'b0;
                    aw_next   = 1'b0;
                    av_next   = 7'd0;
                    nbytes_next = 7'd0;
                    idx_next  = 6'd0;
                    rem1 = remain_reg;
                    if (ev_reset)
                    begin
                        if (!rsth_reg)
                        begin
                            aw_next    = 1'b1;
                            apend_next = 1'b0;
                            rem1       = 8'd0;
                            rsth_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        rsth_next = 1'b0;
                    end
                    remain_next = rem1;
                    cont = (rem1 != 8'd0) && ev_ack && !ev_setup;
                    if (cont)
                    begin
                        chunk       = (rem1 > PKT) ? PKT : rem1;
                        base_next   = offset_reg;
                        offset_next = offset_reg + chunk;
                        remain_next = rem1 - chunk;
                        nbytes_next = chunk[6:0];
                        ctrl_next   = 1'b1;
                        len_next    = chunk[6:0];
                        lbuf_next   = (remain_next == 8'd0);
                        d1_next     = pid_reg;
                        pid_next    = !pid_reg;
                        arm_next    = (remain_next == 8'd0);
                    end
                    if (apend_next && remain_next == 8'd0 && ev_done)
                    begin
                        aw_next    = 1'b1;
                        av_next    = paddr_reg;
                        apend_next = 1'b0;
                    end
                    if (ev_setup)
                    begin
                        ackr = 1'b1;
                        if (kind == KIND_STANDARD)
                        begin
                            if (ev_code == REQ_GET_DESCRIPTOR)
                            begin
                                if (ev_value[15:8] == DESC_DEVICE)
                                begin
                                    start = 1'b1;
                                    ssel  = SEL_DEV;
                                    slen  = (ev_length < 16'(DEV_LEN)) ? ev_length[7:0] : DEV_LEN;
                                end
                                else if (ev_value[15:8] == DESC_CONFIG)
                                begin
                                    start = 1'b1;
                                    ssel  = SEL_CFG;
                                    slen  = (ev_length < 16'(CFG_LEN)) ? ev_length[7:0] : CFG_LEN;
                                end
                                else if (ev_value[15:8] == DESC_STRING && ev_value[7:0] <= 8'd2)
                                begin
                                    start = 1'b1;
                                    case (ev_value[1:0])
                                        2'd0:    begin ssel = SEL_LANG; slen = LANG_LEN; end
                                        2'd1:    begin ssel = SEL_MFG;  slen = MFG_LEN;  end
                                        default: begin ssel = SEL_PROD; slen = PROD_LEN; end
                                    endcase
                                end
                            end
                            else if (ev_code == REQ_SET_ADDRESS)
                            begin
                                paddr_next = ev_value[6:0];
                                apend_next = 1'b1;
                            end
                        end
                        else if (kind == KIND_CLASS && ev_code == REQ_GET_LINE_CODING)
                        begin
                            start = 1'b1;
                            ssel  = SEL_CODING;
                            slen  = CODING_LEN;
                        end
                        if (start)
                        begin
                            chunk       = (slen > PKT) ? PKT : slen;
                            sel_next    = ssel;
                            base_next   = 8'd0;
                            offset_next = chunk;
                            remain_next = slen - chunk;
                            nbytes_next = chunk[6:0];
                            ctrl_next   = 1'b1;
                            len_next    = chunk[6:0];
                            lbuf_next   = (remain_next == 8'd0);
                            d1_next     = 1'b1;
                            pid_next    = 1'b0;
                            arm_next    = (remain_next == 8'd0);
                        end
                        else if (ackr)
                        begin
                            remain_next = 8'd0;
                            ctrl_next   = 1'b1;
                            len_next    = 7'd0;
                            lbuf_next   = 1'b1;
                            d1_next     = 1'b1;
                            arm_next    = 1'b0;
                        end
                    end
                    if (nbytes_next != 7'd0)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (ctrl_next || aw_next)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_tready)
                begin
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic dv;
    assign dv  = (nbytes_reg != 7'd0);
    assign fin = !dv || ({1'b0, idx_reg} + 7'd1 == nbytes_reg);

    assign out_tvalid = (state_reg == ST_EMIT);
    assign out_tlast  = fin;
    assign out_tdata[7:0]   = dv ? rom_data : 8'd0;
    assign out_tdata[13:8]  = dv ? idx_reg : 6'd0;
    assign out_tdata[14]    = dv;
    assign out_tdata[15]    = fin & ctrl_reg;
    assign out_tdata[22:16] = (fin & ctrl_reg) ? len_reg : 7'd0;
    assign out_tdata[23]    = fin & ctrl_reg & lbuf_reg;
    assign out_tdata[24]    = fin & ctrl_reg & d1_reg;
    assign out_tdata[25]    = fin & arm_reg;
    assign out_tdata[26]    = fin & aw_reg;
    assign out_tdata[33:27] = (fin & aw_reg) ? av_reg : 7'd0;
    assign out_tdata[39:34] = 6'd0;

    `USBCER_ASSERT_IMP(a_no_take_while_out, out_tvalid, !in_tready)
    `USBCER_ASSERT_NXT(a_fetch_then_emit, state_reg == ST_FETCH, state_reg == ST_EMIT)
    `USBCER_ASSERT_IMP(a_ctrl_on_last, out_tvalid && out_tdata[15], out_tlast)
    `USBCER_ASSERT_NXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)
endmodule
